// ----- rtl/core/duration_text_to_minutes_macros.svh -----
`ifndef DURATION_TEXT_TO_MINUTES_MACROS_SVH
`define DURATION_TEXT_TO_MINUTES_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/dtm_pkg.sv -----
`timescale 1ns / 1ps
package dtm_pkg;

	localparam logic [10:0] MAX_TOTAL_RST = 11'd1440;
	localparam logic [16:0] CAP_RST       = 17'd86400;  // 1440 * 60

	typedef struct packed {
		logic [7:0] char_byte;
		logic       no_char;
		logic       last;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [10:0] total_minutes;
		logic [3:0]  status;
	} res_t;

	typedef enum logic [3:0] {
		ST_OK            = 4'd0,
		ST_EMPTY         = 4'd1,
		ST_NO_NUMBER     = 4'd2,
		ST_TOO_LARGE     = 4'd3,
		ST_UNITLESS      = 4'd4,
		ST_HOURS         = 4'd5,
		ST_MINUTES_TWICE = 4'd6,
		ST_SECONDS       = 4'd7,
		ST_BAD_UNIT      = 4'd8,
		ST_ZERO          = 4'd9,
		ST_OVER          = 4'd10
	} status_t;

	// character classes produced by the front end
	typedef enum logic [2:0] {
		CC_NONE  = 3'd0,
		CC_WS    = 3'd1,
		CC_DIGIT = 3'd2,
		CC_H     = 3'd3,
		CC_M     = 3'd4,
		CC_S     = 3'd5,
		CC_OTHER = 3'd6
	} cls_t;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'b001,
		PH_EXPECT = 3'b010,
		PH_DIGITS = 3'b100
	} phase_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] dval;
		logic       last;
	} qent_t;

	// parser state captured at end of string
	typedef struct packed {
		status_t     err;
		phase_t      phase;
		logic        ovf;
		logic        seen;
		logic [16:0] dig;
		logic [22:0] tot;
	} fin_t;

endpackage

// ----- rtl/core/dtm_front.sv -----
`timescale 1ns / 1ps
module dtm_front (
	input  dtm_pkg::req_t  req,
	input  logic           take,
	output logic           push,
	output dtm_pkg::qent_t ent
);

	logic [7:0] c;

	assign c = req.char_byte;

	always_comb begin
		ent.dval = c[3:0];
		ent.last = req.last;
		if (req.no_char) begin
			ent.cls = dtm_pkg::CC_NONE;
		end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
			ent.cls = dtm_pkg::CC_WS;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			ent.cls = dtm_pkg::CC_DIGIT;
		end else if (c == 8'h68 || c == 8'h48) begin
			ent.cls = dtm_pkg::CC_H;
		end else if (c == 8'h6D || c == 8'h4D) begin
			ent.cls = dtm_pkg::CC_M;
		end else if (c == 8'h73 || c == 8'h53) begin
			ent.cls = dtm_pkg::CC_S;
		end else begin
			ent.cls = dtm_pkg::CC_OTHER;
		end
	end

	// an empty item that does not end the string has no effect: drop it here
	assign push = take && !(req.no_char && !req.last);

endmodule

// ----- rtl/core/dtm_queue.sv -----
`timescale 1ns / 1ps
`include "duration_text_to_minutes_macros.svh"
module dtm_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dtm_pkg::qent_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output dtm_pkg::qent_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	dtm_pkg::qent_t ent_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full     = (cnt_q == CNT_FULL);
	assign nonempty = (cnt_q != '0);
	assign head     = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`DTM_ASSERT_IMP(a_q_no_overrun, full, !push || pop, "queue write while full")
	`DTM_ASSERT_NXT(a_q_drain, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "queue count off on read")

endmodule

// ----- rtl/core/dtm_back.sv -----
`timescale 1ns / 1ps
`include "duration_text_to_minutes_macros.svh"
module dtm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wen,
	input  logic [10:0]    cfg_wdata,
	input  logic           q_valid,
	input  dtm_pkg::qent_t head,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_ready,
	output dtm_pkg::res_t  res
);

	// configuration
	logic [10:0] max_q;
	logic [16:0] cap_q;

	// parser state
	dtm_pkg::phase_t  phase_q, n_phase;
	dtm_pkg::status_t err_q, n_err;
	logic [16:0]      dig_q, n_dig;
	logic [22:0]      tot_q, n_tot;
	logic             ovf_q, n_ovf;
	logic             sh_q, n_sh;
	logic             sm_q, n_sm;
	logic             pend_q, n_pend;

	logic [20:0] v10;
	logic [22:0] hr;

	// end-of-string stage and output register
	dtm_pkg::fin_t    fin_s1;
	logic             fin_v_s1;
	logic             fin_adv;
	logic             fin_free;
	dtm_pkg::res_t    res_q;
	logic             res_valid_q;
	dtm_pkg::status_t st;
	logic [22:0]      total;

	assign fin_adv  = fin_v_s1 && (!res_valid_q || res_ready);
	assign fin_free = !fin_v_s1 || fin_adv;
	assign pop      = q_valid && (!head.last || fin_free);

	assign v10 = 21'({dig_q, 3'b000}) + 21'({dig_q, 1'b0}) + 21'(head.dval);
	assign hr  = {dig_q, 6'b000000} - 23'({dig_q, 2'b00});

	always_comb begin
		n_phase = phase_q;
		n_err   = err_q;
		n_dig   = dig_q;
		n_tot   = tot_q;
		n_ovf   = ovf_q;
		n_sh    = sh_q;
		n_sm    = sm_q;
		n_pend  = pend_q;
		case (head.cls)
			dtm_pkg::CC_NONE: begin
			end
			dtm_pkg::CC_WS: begin
				if (phase_q != dtm_pkg::PH_LEAD) begin
					n_pend = 1'b1;
				end
			end
			default: begin
				n_pend = 1'b0;
				if (err_q != dtm_pkg::ST_OK) begin
					n_err = err_q;
				end else if (pend_q) begin
					// held space is parsed as a character: always an error
					if (phase_q == dtm_pkg::PH_DIGITS) begin
						n_err = ovf_q ? dtm_pkg::ST_TOO_LARGE : dtm_pkg::ST_BAD_UNIT;
					end else begin
						n_err = dtm_pkg::ST_NO_NUMBER;
					end
				end else if (phase_q != dtm_pkg::PH_DIGITS) begin
					if (head.cls != dtm_pkg::CC_DIGIT) begin
						n_err = dtm_pkg::ST_NO_NUMBER;
					end else begin
						n_phase = dtm_pkg::PH_DIGITS;
						n_ovf   = 1'b0;
						n_dig   = 17'(head.dval);
						if (17'(head.dval) > cap_q) begin
							n_ovf = 1'b1;
							n_dig = cap_q;
						end
					end
				end else if (head.cls == dtm_pkg::CC_DIGIT) begin
					if (!ovf_q) begin
						if (v10 > 21'(cap_q)) begin
							n_ovf = 1'b1;
							n_dig = cap_q;
						end else begin
							n_dig = v10[16:0];
						end
					end
				end else if (ovf_q) begin
					n_err = dtm_pkg::ST_TOO_LARGE;
				end else begin
					case (head.cls)
						dtm_pkg::CC_H: begin
							if (sh_q || sm_q) begin
								n_err = dtm_pkg::ST_HOURS;
							end else begin
								n_sh    = 1'b1;
								n_tot   = tot_q + hr;
								n_phase = dtm_pkg::PH_EXPECT;
								n_dig   = '0;
							end
						end
						dtm_pkg::CC_M: begin
							if (sm_q) begin
								n_err = dtm_pkg::ST_MINUTES_TWICE;
							end else begin
								n_sm    = 1'b1;
								n_tot   = tot_q + 23'(dig_q);
								n_phase = dtm_pkg::PH_EXPECT;
								n_dig   = '0;
							end
						end
						dtm_pkg::CC_S: begin
							n_err = dtm_pkg::ST_SECONDS;
						end
						default: begin
							n_err = dtm_pkg::ST_BAD_UNIT;
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= dtm_pkg::MAX_TOTAL_RST;
			cap_q <= dtm_pkg::CAP_RST;
		end else if (cfg_wen) begin
			max_q <= cfg_wdata;
			cap_q <= {cfg_wdata, 6'b000000} - 17'({cfg_wdata, 2'b00});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtm_pkg::PH_LEAD;
			err_q   <= dtm_pkg::ST_OK;
			dig_q   <= '0;
			tot_q   <= '0;
			ovf_q   <= 1'b0;
			sh_q    <= 1'b0;
			sm_q    <= 1'b0;
			pend_q  <= 1'b0;
		end else if (pop) begin
			if (head.last) begin
				phase_q <= dtm_pkg::PH_LEAD;
				err_q   <= dtm_pkg::ST_OK;
				dig_q   <= '0;
				tot_q   <= '0;
				ovf_q   <= 1'b0;
				sh_q    <= 1'b0;
				sm_q    <= 1'b0;
				pend_q  <= 1'b0;
			end else begin
				phase_q <= n_phase;
				err_q   <= n_err;
				dig_q   <= n_dig;
				tot_q   <= n_tot;
				ovf_q   <= n_ovf;
				sh_q    <= n_sh;
				sm_q    <= n_sm;
				pend_q  <= n_pend;
			end
		end
	end

	// snapshot of the final state
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			fin_s1.err   <= n_err;
			fin_s1.phase <= n_phase;
			fin_s1.ovf   <= n_ovf;
			fin_s1.seen  <= n_sh || n_sm;
			fin_s1.dig   <= n_dig;
			fin_s1.tot   <= n_tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
		end else if (pop && head.last) begin
			fin_v_s1 <= 1'b1;
		end else if (fin_adv) begin
			fin_v_s1 <= 1'b0;
		end
	end

	// final checks
	assign total = (fin_s1.phase == dtm_pkg::PH_DIGITS) ? 23'(fin_s1.dig) : fin_s1.tot;

	always_comb begin
		if (fin_s1.err != dtm_pkg::ST_OK) begin
			st = fin_s1.err;
		end else if (fin_s1.phase == dtm_pkg::PH_LEAD) begin
			st = dtm_pkg::ST_EMPTY;
		end else if (fin_s1.phase == dtm_pkg::PH_DIGITS && fin_s1.ovf) begin
			st = dtm_pkg::ST_TOO_LARGE;
		end else if (fin_s1.phase == dtm_pkg::PH_DIGITS && fin_s1.seen) begin
			st = dtm_pkg::ST_UNITLESS;
		end else if (total == '0) begin
			st = dtm_pkg::ST_ZERO;
		end else if (total > 23'(max_q)) begin
			st = dtm_pkg::ST_OVER;
		end else begin
			st = dtm_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_adv) begin
			res_q.accepted      <= (st == dtm_pkg::ST_OK);
			res_q.total_minutes <= (st == dtm_pkg::ST_OK) ? total[10:0] : '0;
			res_q.status        <= st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`DTM_ASSERT_IMP(a_ok_nonzero, res_valid && res.status == dtm_pkg::ST_OK, res.accepted && res.total_minutes != 11'd0, "accepted result with zero total")
	`DTM_ASSERT_NXT(a_clear_after_last, pop && head.last, phase_q == dtm_pkg::PH_LEAD && err_q == dtm_pkg::ST_OK && !pend_q, "parser not cleared after string end")
	`DTM_ASSERT_NXT(a_fin_hold, fin_v_s1 && res_valid && !res_ready, fin_v_s1, "end-of-string snapshot lost under stall")
	`DTM_ASSERT_NXT(a_err_sticky, pop && !head.last && err_q != dtm_pkg::ST_OK, err_q == $past(err_q), "first error overwritten")

endmodule

// ----- rtl/core/duration_text_to_minutes.sv -----
`timescale 1ns / 1ps
// Channel   | Handshake              | Payload                             | Role
// request   | req_valid / req_ready  | req  (char_byte, no_char, last)     | one character in
// result    | res_valid / res_ready  | res  (accepted, total_minutes, status) | one per string
// config    | cfg_wen                | cfg_wdata (max_total_minutes)       | write, no wait
//
// One request per cycle sustained while results are taken; the parser consumes one character a cycle.
// A result for the request marked last passes, in order, through the queue,
// the parser, the end-of-string stage and the output register.
// Reset (arst_n low) clears the parser and restores max_total_minutes to 1440.
// A stalled result holds the snapshot stage; the parser then stops only on the
// next end-of-string request, and req_ready drops once the queue fills.
module duration_text_to_minutes #(
	parameter int QDEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dtm_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output dtm_pkg::res_t res,
	input  logic          cfg_wen,
	input  logic [10:0]   cfg_wdata
);

	logic           q_full;
	logic           q_valid;
	logic           push;
	logic           pop;
	dtm_pkg::qent_t push_ent;
	dtm_pkg::qent_t head;

	// front end takes a request whenever the queue has room
	assign req_ready = !q_full;

	// classify each character (digit, space, unit letter, other)
	dtm_front u_front (
		.req  (req),
		.take (req_valid && req_ready),
		.push (push),
		.ent  (push_ent)
	);

	// short queue decouples intake from the parser
	dtm_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_ent),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_valid),
		.head      (head)
	);

	// parser, final checks and output register
	dtm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
